// ----- design/mfi_pkg.sv -----
// shared constants for the isap max flow engine
package mfi_pkg;

    localparam int DEF_MAX_NODES      = 1024;
    localparam int DEF_MAX_EDGE_PAIRS = 4096;

    // request commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    // configuration register indexes
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_SINK   = 1'b1;

    localparam logic [30:0] PATH_START = 31'd999999999;
    localparam logic [30:0] RES_MAX    = 31'h7FFFFFFF;
    localparam logic [31:0] FLOW_MAX   = 32'hFFFFFFFF;

    localparam int NODE_FIELD_W = 11;
    localparam int CAP_W        = 31;
    localparam int FLOW_W       = 32;

endpackage

// ----- design/max_flow_isap_engine_unit.sv -----
// top level of the isap max flow engine
// Max-flow engine over a stored residual graph (ISAP with current arcs and the gap
// heuristic). One request gives one result. A clear request sweeps the adjacency
// heads; the same sweep runs after reset, and no request is taken during it. An add
// request reads and relinks the from node's list head and then the to node's, storing
// a forward and a reverse arc; an ignored or dropped one goes straight to its result.
// A run first sets up every node up to the sink and the distance histogram, then scans
// arcs, augments and retreats, all bound by the single read port of each state memory.
// Configuration writes are taken at once.
module max_flow_isap_engine_unit
    import mfi_pkg::*;
#(
    parameter int MAX_NODES      = DEF_MAX_NODES,
    parameter int MAX_EDGE_PAIRS = DEF_MAX_EDGE_PAIRS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], from_node[12:2], to_node[23:13], capacity[54:24],
    // reverse_capacity[85:55], zero fill
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], flow_value[32:1], zero fill
    output logic [39:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int NAW   = $clog2(MAX_NODES + 1);
    localparam int DW    = $clog2(MAX_NODES + 3);
    localparam int SLOTS = 2 * MAX_EDGE_PAIRS + 2;
    localparam int EW    = $clog2(SLOTS);

    typedef enum logic [5:0] {
        ST_CLR, ST_IDLE, ST_ADD0, ST_ADD1, ST_ADD2, ST_ADD3,
        ST_INIT0, ST_INIT1, ST_CNT, ST_F0, ST_F1,
        ST_SCAN0, ST_SCAN1, ST_SCAN2, ST_ADV0, ST_ADV1,
        ST_AUG0, ST_AUG1, ST_AUG2, ST_AUG3,
        ST_RET0, ST_RET1, ST_RET2, ST_RS0, ST_RS1, ST_RS2,
        ST_RET3, ST_RET4, ST_RET5, ST_RET6, ST_DONE
    } state_t;

    state_t state_reg;

    logic             boot_reg;
    logic [10:0]      source_reg, sink_reg;
    logic [NAW-1:0]   s_reg, t_reg, x_reg, v_reg, a_reg, b_reg, i_reg;
    logic [DW-1:0]    ci_reg, dx_reg, ndx_reg;
    logic [EW-1:0]    ec_reg, p_reg, nx_reg, e_reg;
    logic [CAP_W-1:0] r_reg, d_reg, fcap_reg, rcap_reg;
    logic [FLOW_W-1:0] sum_reg;
    logic             res_status_reg;
    logic [FLOW_W-1:0] res_flow_reg;
    logic             m_valid_reg, m_status_reg;
    logic [FLOW_W-1:0] m_flow_reg;

    // request fields
    logic [1:0]       in_cmd;
    logic [10:0]      in_from, in_to;
    logic [CAP_W-1:0] in_cap, in_rcap;
    assign in_cmd  = s_tdata[1:0];
    assign in_from = s_tdata[12:2];
    assign in_to   = s_tdata[23:13];
    assign in_cap  = s_tdata[54:24];
    assign in_rcap = s_tdata[85:55];

    // memory ports
    logic            head_we, tgt_we, nxt_we, res_we, dist_we, cur_we, par_we, bn_we, cnt_we;
    logic [NAW-1:0]  head_wa, head_ra, dist_wa, dist_ra, cur_wa, cur_ra, par_wa, par_ra;
    logic [NAW-1:0]  bn_wa, bn_ra;
    logic [EW-1:0]   head_wd, tgt_wa, tgt_ra, nxt_wa, nxt_ra, nxt_wd, res_wa, res_ra;
    logic [EW-1:0]   head_q, nxt_q, cur_wd, cur_q, par_wd, par_q;
    logic [NAW-1:0]  tgt_wd, tgt_q;
    logic [CAP_W-1:0] res_wd, res_q, bn_wd, bn_q;
    logic [DW-1:0]   dist_wd, dist_q, cnt_wa, cnt_ra, cnt_wd, cnt_q;

    mfi_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 1)) u_head (
        .aclk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_q));
    mfi_ram #(.WIDTH(NAW), .DEPTH(SLOTS)) u_tgt (
        .aclk, .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_q));
    mfi_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_nxt (
        .aclk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_q));
    mfi_ram #(.WIDTH(CAP_W), .DEPTH(SLOTS)) u_res (
        .aclk, .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_q));
    mfi_ram #(.WIDTH(DW), .DEPTH(MAX_NODES + 1)) u_dist (
        .aclk, .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra),
        .rdata(dist_q));
    mfi_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 1)) u_cur (
        .aclk, .we(cur_we), .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_q));
    mfi_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 1)) u_par (
        .aclk, .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_q));
    mfi_ram #(.WIDTH(CAP_W), .DEPTH(MAX_NODES + 1)) u_bn (
        .aclk, .we(bn_we), .waddr(bn_wa), .wdata(bn_wd), .raddr(bn_ra), .rdata(bn_q));
    mfi_ram #(.WIDTH(DW), .DEPTH(MAX_NODES + 3)) u_cnt (
        .aclk, .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_q));

    // shared decisions
    logic              arc_ok, adm_ok, relabel_ok;
    logic              nodes_ok, add_full;
    logic [CAP_W-1:0]  bmin;
    logic [FLOW_W:0]   sum_wide;
    logic [FLOW_W:0]   res_grow;
    logic [31:0]       from32, to32, src32, snk32;
    logic              out_free;

    assign from32     = 32'(in_from);
    assign to32       = 32'(in_to);
    assign src32      = 32'(source_reg);
    assign snk32      = 32'(sink_reg);
    assign nodes_ok   = !(from32 < 1 || from32 > MAX_NODES || to32 < 1 || to32 > MAX_NODES);
    assign add_full   = (32'(ec_reg) + 32'd2 > 32'(2 * MAX_EDGE_PAIRS + 1));
    assign arc_ok     = (res_q != '0) && (tgt_q <= t_reg);
    assign adm_ok     = ((DW+1)'(dist_q) + (DW+1)'(1)) == (DW+1)'(dx_reg);
    // a self loop never lowers the label of the node being relabelled
    assign relabel_ok = (((DW+1)'(dist_q) + (DW+1)'(1)) < (DW+1)'(ndx_reg)) &&
                        (tgt_q != x_reg);
    assign bmin       = (r_reg < bn_q) ? r_reg : bn_q;
    assign sum_wide   = (FLOW_W+1)'(sum_reg) + (FLOW_W+1)'(bmin);
    assign res_grow   = (FLOW_W+1)'(res_q) + (FLOW_W+1)'(d_reg);
    assign out_free   = !m_valid_reg || m_tready;

    // memory address and write control
    always_comb begin
        head_we = 1'b0; head_wa = i_reg; head_wd = '0; head_ra = x_reg;
        tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_ra = p_reg;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = p_reg;
        res_we = 1'b0; res_wa = '0; res_wd = '0; res_ra = p_reg;
        dist_we = 1'b0; dist_wa = i_reg; dist_wd = '0; dist_ra = x_reg;
        cur_we = 1'b0; cur_wa = x_reg; cur_wd = p_reg; cur_ra = x_reg;
        par_we = 1'b0; par_wa = v_reg; par_wd = p_reg; par_ra = x_reg;
        bn_we = 1'b0; bn_wa = v_reg; bn_wd = bmin; bn_ra = x_reg;
        cnt_we = 1'b0; cnt_wa = ci_reg; cnt_wd = '0; cnt_ra = dx_reg;
        case (state_reg)
            ST_CLR: begin
                head_we = 1'b1;
            end
            ST_ADD0: head_ra = a_reg;
            ST_ADD1: begin
                head_we = 1'b1; head_wa = a_reg; head_wd = ec_reg + EW'(1);
                tgt_we = 1'b1; tgt_wa = ec_reg + EW'(1); tgt_wd = b_reg;
                nxt_we = 1'b1; nxt_wa = ec_reg + EW'(1); nxt_wd = head_q;
                res_we = 1'b1; res_wa = ec_reg + EW'(1); res_wd = fcap_reg;
            end
            ST_ADD2: head_ra = b_reg;
            ST_ADD3: begin
                head_we = 1'b1; head_wa = b_reg; head_wd = ec_reg + EW'(2);
                tgt_we = 1'b1; tgt_wa = ec_reg + EW'(2); tgt_wd = a_reg;
                nxt_we = 1'b1; nxt_wa = ec_reg + EW'(2); nxt_wd = head_q;
                res_we = 1'b1; res_wa = ec_reg + EW'(2); res_wd = rcap_reg;
            end
            ST_INIT0: head_ra = i_reg;
            ST_INIT1: begin
                dist_we = 1'b1;
                dist_wd = (i_reg == t_reg) ? DW'(0) : DW'(1);
                cur_we = 1'b1; cur_wa = i_reg; cur_wd = head_q;
                par_we = 1'b1; par_wa = i_reg; par_wd = '0;
                bn_we = 1'b1; bn_wa = i_reg;
                bn_wd = (i_reg == s_reg) ? PATH_START : '0;
            end
            ST_CNT: begin
                cnt_we = 1'b1;
                if (ci_reg == DW'(0)) begin
                    cnt_wd = DW'(1);
                end else if (ci_reg == DW'(1)) begin
                    cnt_wd = DW'(t_reg) - DW'(1);
                end
            end
            ST_SCAN1, ST_RS1: dist_ra = tgt_q;
            ST_ADV0: begin
                cur_we = 1'b1;
                par_we = 1'b1;
            end
            ST_ADV1: bn_we = 1'b1;
            ST_AUG1: res_ra = par_q;
            ST_AUG2: begin
                res_we = 1'b1; res_wa = e_reg; res_wd = res_q - d_reg;
                res_ra = e_reg ^ EW'(1); tgt_ra = e_reg ^ EW'(1);
            end
            ST_AUG3: begin
                res_we = 1'b1; res_wa = e_reg ^ EW'(1);
                res_wd = (res_grow > (FLOW_W+1)'(RES_MAX)) ? RES_MAX : res_q + d_reg;
            end
            ST_RET1: begin
                cnt_we = 1'b1; cnt_wa = dx_reg; cnt_wd = cnt_q - DW'(1);
            end
            ST_RS2: cur_we = relabel_ok;
            ST_RET3: begin
                dist_we = 1'b1; dist_wa = x_reg; dist_wd = ndx_reg;
                cnt_ra = ndx_reg;
            end
            ST_RET4: begin
                cnt_we = 1'b1; cnt_wa = ndx_reg; cnt_wd = cnt_q + DW'(1);
            end
            ST_RET5: tgt_ra = par_q ^ EW'(1);
            default: ;
        endcase
    end

    // sequencer state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            boot_reg    <= 1'b1;
            i_reg       <= '0;
            ec_reg      <= EW'(1);
            source_reg  <= 11'd1;
            sink_reg    <= 11'd2;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SOURCE: source_reg <= cfg_data;
                    REG_SINK:   sink_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                // head sweep; the one after reset gives no result
                ST_CLR: begin
                    i_reg <= i_reg + NAW'(1);
                    if (32'(i_reg) == MAX_NODES) begin
                        ec_reg <= EW'(1);
                        boot_reg <= 1'b0;
                        state_reg <= boot_reg ? ST_IDLE : ST_DONE;
                    end
                end
                ST_IDLE: begin
                    res_status_reg <= (in_cmd == CMD_ADD) && nodes_ok && add_full;
                    res_flow_reg   <= '0;
                    if (s_tvalid) begin
                        a_reg <= NAW'(in_from);
                        b_reg <= NAW'(in_to);
                        fcap_reg <= in_cap;
                        rcap_reg <= in_rcap;
                        s_reg <= NAW'(source_reg);
                        t_reg <= NAW'(sink_reg);
                        sum_reg <= '0;
                        case (in_cmd)
                            CMD_CLEAR: begin
                                i_reg <= '0;
                                state_reg <= ST_CLR;
                            end
                            CMD_ADD: begin
                                if (!nodes_ok || add_full) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    state_reg <= ST_ADD0;
                                end
                            end
                            CMD_RUN: begin
                                if (snk32 < 2 || snk32 > MAX_NODES ||
                                    src32 < 1 || src32 >= snk32) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    i_reg <= NAW'(1);
                                    state_reg <= ST_INIT0;
                                end
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_ADD0: state_reg <= ST_ADD1;
                ST_ADD1: state_reg <= ST_ADD2;
                ST_ADD2: state_reg <= ST_ADD3;
                ST_ADD3: begin
                    ec_reg <= ec_reg + EW'(2);
                    state_reg <= ST_DONE;
                end
                // per node set-up
                ST_INIT0: state_reg <= ST_INIT1;
                ST_INIT1: begin
                    i_reg <= i_reg + NAW'(1);
                    if (i_reg == t_reg) begin
                        ci_reg <= '0;
                        state_reg <= ST_CNT;
                    end else begin
                        state_reg <= ST_INIT0;
                    end
                end
                // distance histogram set-up
                ST_CNT: begin
                    ci_reg <= ci_reg + DW'(1);
                    if (32'(ci_reg) == MAX_NODES + 2) begin
                        x_reg <= s_reg;
                        state_reg <= ST_F0;
                    end
                end
                ST_F0: state_reg <= ST_F1;
                ST_F1: begin
                    p_reg <= cur_q;
                    dx_reg <= dist_q;
                    state_reg <= ST_SCAN0;
                end
                // admissible arc search from the current arc
                ST_SCAN0: state_reg <= (p_reg == '0) ? ST_RET0 : ST_SCAN1;
                ST_SCAN1: begin
                    v_reg <= tgt_q;
                    r_reg <= res_q;
                    nx_reg <= nxt_q;
                    if (arc_ok) begin
                        state_reg <= ST_SCAN2;
                    end else begin
                        p_reg <= nxt_q;
                        state_reg <= ST_SCAN0;
                    end
                end
                ST_SCAN2: begin
                    if (adm_ok) begin
                        state_reg <= ST_ADV0;
                    end else begin
                        p_reg <= nx_reg;
                        state_reg <= ST_SCAN0;
                    end
                end
                ST_ADV0: state_reg <= ST_ADV1;
                ST_ADV1: begin
                    x_reg <= v_reg;
                    if (v_reg == t_reg) begin
                        d_reg <= bmin;
                        sum_reg <= sum_wide[FLOW_W] ? FLOW_MAX : sum_wide[FLOW_W-1:0];
                        state_reg <= ST_AUG0;
                    end else begin
                        state_reg <= ST_F0;
                    end
                end
                // push the bottleneck back along the parent arcs
                ST_AUG0: state_reg <= (x_reg == s_reg) ? ST_F0 : ST_AUG1;
                ST_AUG1: begin
                    e_reg <= par_q;
                    state_reg <= ST_AUG2;
                end
                ST_AUG2: state_reg <= ST_AUG3;
                ST_AUG3: begin
                    x_reg <= tgt_q;
                    state_reg <= ST_AUG0;
                end
                // retreat with gap check and relabel
                ST_RET0: state_reg <= ST_RET1;
                ST_RET1: begin
                    if (cnt_q == DW'(1)) begin
                        res_flow_reg <= sum_reg;
                        state_reg <= ST_DONE;
                    end else begin
                        ndx_reg <= DW'(t_reg) + DW'(1);
                        state_reg <= ST_RET2;
                    end
                end
                ST_RET2: begin
                    p_reg <= head_q;
                    state_reg <= ST_RS0;
                end
                ST_RS0: state_reg <= (p_reg == '0) ? ST_RET3 : ST_RS1;
                ST_RS1: begin
                    nx_reg <= nxt_q;
                    if (arc_ok) begin
                        state_reg <= ST_RS2;
                    end else begin
                        p_reg <= nxt_q;
                        state_reg <= ST_RS0;
                    end
                end
                ST_RS2: begin
                    if (relabel_ok) begin
                        ndx_reg <= dist_q + DW'(1);
                    end
                    p_reg <= nx_reg;
                    state_reg <= ST_RS0;
                end
                ST_RET3: state_reg <= ST_RET4;
                ST_RET4: begin
                    if (x_reg == s_reg) begin
                        if ((DW+1)'(ndx_reg) > (DW+1)'(t_reg)) begin
                            res_flow_reg <= sum_reg;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_F0;
                        end
                    end else begin
                        state_reg <= ST_RET5;
                    end
                end
                ST_RET5: state_reg <= ST_RET6;
                ST_RET6: begin
                    x_reg <= tgt_q;
                    state_reg <= ST_F0;
                end
                // hand the result to the output register
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_flow_reg   <= res_flow_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_flow_reg, m_status_reg};

endmodule

// ----- design/mfi_ram.sv -----
// generic simple dual port ram with registered read
module mfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
